[src/m3i_pkg.sv]
// shared types and constants for the 3x3 matrix inverse
// no dependencies
`timescale 1ns / 1ps

package m3i_pkg;

   localparam int ENT_W = 32;
   localparam int COF_W = 65;
   localparam int DET_W = 99;
   localparam int NUM_ENT = 9;

   typedef logic signed [ENT_W-1:0] ent_type;
   typedef logic signed [COF_W-1:0] cof_type;
   typedef logic signed [DET_W-1:0] det_type;

   // cofactor k = a[P]*a[Q] - a[R]*a[S], entries indexed row*3+col
   localparam int COF_P [NUM_ENT] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
   localparam int COF_Q [NUM_ENT] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
   localparam int COF_R [NUM_ENT] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
   localparam int COF_S [NUM_ENT] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};

endpackage

[src/m3i_cofactor.sv]
// adjugate cofactors: products, then differences, two register stages
// depends on m3i_pkg
`timescale 1ns / 1ps

module m3i_cofactor (
   input  logic             clock,
   input  logic             en,
   input  m3i_pkg::ent_type a   [9],
   output m3i_pkg::cof_type cof [9],
   output m3i_pkg::ent_type a0  [3]
);
   import m3i_pkg::*;

   logic signed [2*ENT_W-1:0] pp_ff [NUM_ENT];
   logic signed [2*ENT_W-1:0] pq_ff [NUM_ENT];
   ent_type                   a0_s1_ff [3];
   cof_type                   cof_ff [NUM_ENT];
   ent_type                   a0_ff [3];

   // stage 1: eighteen 32x32 products
   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < NUM_ENT; k++) begin
            pp_ff[k] <= a[COF_P[k]] * a[COF_Q[k]];
            pq_ff[k] <= a[COF_R[k]] * a[COF_S[k]];
         end
         for (int j = 0; j < 3; j++) a0_s1_ff[j] <= a[j];
      end
   end

   // stage 2: exact differences
   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < NUM_ENT; k++)
            cof_ff[k] <= COF_W'(pp_ff[k]) - COF_W'(pq_ff[k]);
         for (int j = 0; j < 3; j++) a0_ff[j] <= a0_s1_ff[j];
      end
   end

   assign cof = cof_ff;
   assign a0  = a0_ff;
endmodule

[src/m3i_det.sv]
// determinant by row-0 expansion, cofactor times entry split in two halves
// depends on m3i_pkg
`timescale 1ns / 1ps

module m3i_det (
   input  logic             clock,
   input  logic             en,
   input  m3i_pkg::cof_type cof_i [9],
   input  m3i_pkg::ent_type a0    [3],
   output m3i_pkg::cof_type cof_o [9],
   output m3i_pkg::det_type det
);
   import m3i_pkg::*;

   localparam int PART_W = 65;

   logic signed [PART_W-1:0] lo_ff [3];
   logic signed [PART_W-1:0] hi_ff [3];
   cof_type                  cof_s1_ff [NUM_ENT];
   cof_type                  cof_ff [NUM_ENT];
   det_type                  det_ff;
   det_type                  det_in;

   logic signed [32:0] lo_op [3];
   logic signed [32:0] hi_op [3];

   // low half unsigned, high half signed, each 33x32
   always_comb begin
      for (int j = 0; j < 3; j++) begin
         lo_op[j] = {1'b0, cof_i[3*j][31:0]};
         hi_op[j] = cof_i[3*j][COF_W-1:32];
      end
   end

   // stage 1: partial products
   always_ff @(posedge clock) begin
      if (en) begin
         for (int j = 0; j < 3; j++) begin
            lo_ff[j] <= lo_op[j] * a0[j];
            hi_ff[j] <= hi_op[j] * a0[j];
         end
         cof_s1_ff <= cof_i;
      end
   end

   // stage 2: combine the partials
   always_comb begin
      det_in = '0;
      for (int j = 0; j < 3; j++)
         det_in = det_in + (DET_W'(hi_ff[j]) <<< 32) + DET_W'(lo_ff[j]);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         det_ff <= det_in;
         cof_ff <= cof_s1_ff;
      end
   end

   assign det   = det_ff;
   assign cof_o = cof_ff;
endmodule

[src/m3i_div_lane.sv]
// one inverse entry: pipelined restoring divide of cofactor by determinant,
// one quotient bit a stage, then sign and saturation; depends on m3i_pkg
`timescale 1ns / 1ps

module m3i_div_lane #(
   parameter int FRAC_BITS = 16
) (
   input  logic             clock,
   input  logic             en,
   input  m3i_pkg::cof_type cof,
   input  m3i_pkg::det_type det,
   output logic [31:0]      res
);
   import m3i_pkg::*;

   // quotient bits 32..0 plus one overflow bit
   localparam int QB = 34;
   localparam int RW = DET_W + QB;

   logic [RW-1:0]    rem_ff [QB+1];
   logic [DET_W-1:0] den_ff [QB+1];
   logic [QB-1:0]    q_ff   [QB+1];
   logic             neg_ff [QB+1];
   logic [31:0]      res_ff;
   logic [31:0]      res_in;

   logic [COF_W-1:0] abs_cof;
   logic [DET_W-1:0] abs_det;

   // operand magnitudes
   always_comb begin
      abs_cof = cof[COF_W-1] ? COF_W'(-cof) : COF_W'(cof);
      abs_det = det[DET_W-1] ? DET_W'(-det) : DET_W'(det);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= RW'(abs_cof) << (2 * FRAC_BITS);
         den_ff[0] <= abs_det;
         q_ff[0]   <= '0;
         neg_ff[0] <= cof[COF_W-1] ^ det[DET_W-1];
      end
   end

   // one quotient bit per stage, highest first
   for (genvar s = 0; s < QB; s++) begin : g_step
      localparam int B = QB - 1 - s;
      logic [RW-1:0] shifted;
      logic          ge;

      always_comb begin
         shifted = RW'(den_ff[s]) << B;
         ge      = rem_ff[s] >= shifted;
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[s+1] <= ge ? rem_ff[s] - shifted : rem_ff[s];
            den_ff[s+1] <= den_ff[s];
            q_ff[s+1]   <= q_ff[s] | (QB'(ge) << B);
            neg_ff[s+1] <= neg_ff[s];
         end
      end
   end

   // sign and saturate
   always_comb begin
      logic big;
      big = q_ff[QB][QB-1] | q_ff[QB][32];
      if (!neg_ff[QB]) begin
         res_in = (big || q_ff[QB][31]) ? 32'h7FFF_FFFF : q_ff[QB][31:0];
      end else begin
         res_in = (big || q_ff[QB][31:0] > 32'h8000_0000) ? 32'h8000_0000
                                                           : 32'(-q_ff[QB][31:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) res_ff <= res_in;
   end

   assign res = res_ff;
endmodule

[src/matrix3x3_inverse.sv]
// 3x3 matrix inverse by the adjugate, top level with stream ports
// depends on m3i_pkg, m3i_cofactor, m3i_det, m3i_div_lane
`timescale 1ns / 1ps

// Takes one 3x3 matrix of signed fixed-point entries per word and returns
// its inverse, entries truncated toward zero and saturated, with a flag
// for a zero determinant (entries then zero). A new matrix is taken every
// cycle; each passes the cofactor stages, then the determinant stages,
// and then the nine divider lanes, which produce one quotient bit per
// stage. The whole pipeline advances together and stalls only while a
// finished word waits at the output.
module matrix3x3_inverse #(
   parameter int FRAC_BITS = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // in_r0c0, in_r0c1, in_r0c2, in_r1c0 .. in_r2c2, 32 bits each
   input  logic [287:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // out_r0c0, out_r0c1, out_r0c2, out_r1c0 .. out_r2c2, 32 bits each
   output logic [287:0] rsp_tdata,
   // singular
   output logic         rsp_tuser
);
   import m3i_pkg::*;

   localparam int LANE_LAT = 36;
   localparam int LAT      = 4 + LANE_LAT;

   logic    en;
   ent_type a      [NUM_ENT];
   cof_type cof_s2 [NUM_ENT];
   ent_type a0_s2  [3];
   cof_type cof_s4 [NUM_ENT];
   det_type det_s4;
   logic [31:0] res [NUM_ENT];

   logic vld_ff  [LAT];
   logic sing_ff [LANE_LAT];

   // global advance: move when the output slot is free or being taken
   assign en         = !rsp_tvalid || rsp_tready;
   assign req_tready = en;

   always_comb begin
      for (int k = 0; k < NUM_ENT; k++) a[k] = req_tdata[32*k +: 32];
   end

   m3i_cofactor u_cof (
      .clock (clock),
      .en    (en),
      .a     (a),
      .cof   (cof_s2),
      .a0    (a0_s2)
   );

   m3i_det u_det (
      .clock (clock),
      .en    (en),
      .cof_i (cof_s2),
      .a0    (a0_s2),
      .cof_o (cof_s4),
      .det   (det_s4)
   );

   for (genvar k = 0; k < NUM_ENT; k++) begin : g_lane
      m3i_div_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
         .clock (clock),
         .en    (en),
         .cof   (cof_s4[k]),
         .det   (det_s4),
         .res   (res[k])
      );
   end

   // valid bits along the pipeline
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LAT; i++) vld_ff[i] <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= req_tvalid;
         for (int i = 1; i < LAT; i++) vld_ff[i] <= vld_ff[i-1];
      end
   end

   // singular flag travels beside the lanes
   always_ff @(posedge clock) begin
      if (en) begin
         sing_ff[0] <= det_s4 == '0;
         for (int i = 1; i < LANE_LAT; i++) sing_ff[i] <= sing_ff[i-1];
      end
   end

   // merge the lanes into the output word
   assign rsp_tvalid = vld_ff[LAT-1];
   assign rsp_tuser  = sing_ff[LANE_LAT-1];
   always_comb begin
      for (int k = 0; k < NUM_ENT; k++)
         rsp_tdata[32*k +: 32] = rsp_tuser ? 32'h0 : res[k];
   end

   // a singular word carries zero entries
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == '0)
      else $error("singular word with nonzero entries");

   // input is never held off while the output slot is empty
   assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled with empty output");

   // a word taken at the output leaves room for the next one
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready |-> req_tready)
      else $error("pipeline stalled while output drains");
endmodule

[test/testbench.sv]
// testbench for matrix3x3_inverse: directed table then random matrices
// depends on m3i_pkg and the matrix3x3_inverse rtl
`timescale 1ns / 1ps

module testbench;
   import m3i_pkg::*;

   localparam int FRAC = 16;
   localparam int WATCH_LIMIT = 20000;
   localparam int N_RANDOM = 630;

   typedef struct {
      logic [287:0] ent;
      logic         sing;
      logic         known;
   } inv_word_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [287:0] req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [287:0] rsp_tdata;
   logic         rsp_tuser;

   inv_word_type inverse_queue[$];
   int           errors = 0;
   int           n_sent = 0;
   int           n_got = 0;
   int           n_sing = 0;
   int           n_sat = 0;
   int           idle_cnt = 0;
   bit           quiet = 1'b0;
   bit           sending = 1'b1;
   bit           hold_off = 1'b0;

   matrix3x3_inverse #(.FRAC_BITS(FRAC)) DUT (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // exact 128 bit quotient, truncated and saturated
   function automatic logic [31:0] inv_entry(logic signed [127:0] cof,
                                             logic signed [127:0] det);
      logic signed [127:0] q;
      q = (cof <<< (2 * FRAC)) / det;
      if (q > 128'sd2147483647) return 32'h7FFFFFFF;
      if (q < -128'sd2147483648) return 32'h80000000;
      return q[31:0];
   endfunction

   function automatic inv_word_type invert_matrix(logic [287:0] m);
      logic signed [127:0] a[9];
      logic signed [127:0] c[9];
      logic signed [127:0] det;
      inv_word_type r;
      for (int k = 0; k < 9; k++) a[k] = $signed(m[32*k +: 32]);
      c[0] = a[4]*a[8] - a[5]*a[7];
      c[1] = a[2]*a[7] - a[1]*a[8];
      c[2] = a[1]*a[5] - a[2]*a[4];
      c[3] = a[5]*a[6] - a[3]*a[8];
      c[4] = a[0]*a[8] - a[2]*a[6];
      c[5] = a[2]*a[3] - a[0]*a[5];
      c[6] = a[3]*a[7] - a[4]*a[6];
      c[7] = a[1]*a[6] - a[0]*a[7];
      c[8] = a[0]*a[4] - a[1]*a[3];
      det = a[0]*c[0] + a[1]*c[3] + a[2]*c[6];
      r.known = 1'b1;
      r.ent = '0;
      r.sing = (det == 0);
      if (!r.sing)
         for (int k = 0; k < 9; k++) r.ent[32*k +: 32] = inv_entry(c[k], det);
      return r;
   endfunction

   function automatic logic [287:0] pack9(int e0, int e1, int e2, int e3, int e4,
                                          int e5, int e6, int e7, int e8);
      return {e8, e7, e6, e5, e4, e3, e2, e1, e0};
   endfunction

   // random entry: mostly modest values, sometimes extremes or small ints
   function automatic logic [31:0] rand_entry();
      int sel;
      sel = $urandom_range(0, 9);
      case (sel)
         0: return $urandom;
         1: return $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
         2: return 32'(($signed($urandom_range(0, 8)) - 4) <<< FRAC);
         3: return 32'd0;
         default: return 32'($signed($urandom_range(0, 32'h0007FFFF)) - 32'sh00040000);
      endcase
   endfunction

   function automatic logic [287:0] rand_matrix();
      logic [287:0] m;
      for (int k = 0; k < 9; k++) m[32*k +: 32] = rand_entry();
      // make some rows dependent to hit the singular path
      if ($urandom_range(0, 9) == 0) m[192 +: 96] = m[0 +: 96];
      if ($urandom_range(0, 9) == 0) m[96 +: 96] = m[0 +: 96];
      return m;
   endfunction

   // directed rows; known ones carry a hand-typed expectation
   inv_word_type dir_exp[$];
   logic [287:0] dir_mat[$];

   task automatic add_row(logic [287:0] m, bit typed, logic [287:0] e, bit s);
      inv_word_type w;
      w.ent = e;
      w.sing = s;
      w.known = typed;
      dir_mat.push_back(m);
      dir_exp.push_back(w);
   endtask

   task automatic send_word(logic [287:0] m, inv_word_type w);
      @(negedge clock);
      while (hold_off || (!quiet && $urandom_range(0, 99) < 9)) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= m;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (!w.known) w = invert_matrix(m);
      inverse_queue.push_back(w);
      n_sent++;
   endtask

   localparam int ONE = 1 << FRAC;
   localparam int MAXV = 32'h7FFFFFFF;
   localparam int MINV = 32'h80000000;

   // stimulus
   initial begin
      inv_word_type w;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      add_row('0, 1, '0, 1);
      add_row(pack9(ONE, 0, 0, 0, ONE, 0, 0, 0, ONE), 1,
              pack9(ONE, 0, 0, 0, ONE, 0, 0, 0, ONE), 0);
      add_row(pack9(2*ONE, 0, 0, 0, 2*ONE, 0, 0, 0, 2*ONE), 1,
              pack9(ONE/2, 0, 0, 0, ONE/2, 0, 0, 0, ONE/2), 0);
      add_row(pack9(1, 0, 0, 0, 1, 0, 0, 0, 1), 1,
              pack9(MAXV, 0, 0, 0, MAXV, 0, 0, 0, MAXV), 0);
      add_row(pack9(-1, 0, 0, 0, -1, 0, 0, 0, -1), 1,
              pack9(MINV, 0, 0, 0, MINV, 0, 0, 0, MINV), 0);
      add_row({9{32'h7FFFFFFF}}, 1, '0, 1);
      add_row({9{32'h80000000}}, 1, '0, 1);
      add_row(pack9(MAXV, 0, 0, 0, MAXV, 0, 0, 0, MAXV), 0, '0, 0);
      add_row(pack9(MINV, 0, 0, 0, MINV, 0, 0, 0, MINV), 0, '0, 0);
      add_row(pack9(MINV, MAXV, 0, MAXV, MINV, MAXV, 0, MINV, MAXV), 0, '0, 0);
      add_row(pack9(0, ONE, 0, ONE, 0, 0, 0, 0, ONE), 0, '0, 0);
      add_row(pack9(ONE, 2*ONE, 3*ONE, 4*ONE, 5*ONE, 6*ONE, 7*ONE, 8*ONE, 10*ONE),
              0, '0, 0);
      add_row(pack9(ONE, 2*ONE, 3*ONE, 4*ONE, 5*ONE, 6*ONE, 7*ONE, 8*ONE, 9*ONE),
              1, '0, 1);
      add_row(pack9(3, -7, 11, 0, 5, 2, -9, 4, 1), 0, '0, 0);
      add_row({9{32'hFFFFFFFF}}, 1, '0, 1);
      for (int i = 0; i < dir_mat.size(); i++) send_word(dir_mat[i], dir_exp[i]);
      // hold the sender until the pipeline drains
      hold_off = 1'b1;
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (inverse_queue.size() != 0) @(negedge clock);
      hold_off = 1'b0;
      for (int i = 0; i < N_RANDOM; i++) begin
         quiet = (i >= 200 && i < 300);
         w.known = 1'b0;
         send_word(rand_matrix(), w);
      end
      @(negedge clock);
      req_tvalid <= 1'b0;
      sending = 1'b0;
   end

   // receiver stalls
   always @(negedge clock)
      rsp_tready <= quiet ? 1'b1 : ($urandom_range(0, 99) >= 9);

   // result checking
   always @(posedge clock) begin
      inv_word_type w;
      if (!reset && rsp_tvalid && rsp_tready) begin
         n_got++;
         if (inverse_queue.size() == 0) begin
            $display("%0t: unexpected word %h %b", $time, rsp_tdata, rsp_tuser);
            errors++;
         end else begin
            w = inverse_queue.pop_front();
            if (w.sing) n_sing++;
            for (int k = 0; k < 9; k++) begin
               if (w.ent[32*k +: 32] == 32'h7FFFFFFF || w.ent[32*k +: 32] == 32'h80000000)
                  n_sat++;
               if (rsp_tdata[32*k +: 32] !== w.ent[32*k +: 32]) begin
                  $display("%0t: entry %0d expected %h actual %h", $time, k,
                           w.ent[32*k +: 32], rsp_tdata[32*k +: 32]);
                  errors++;
               end
            end
            if (rsp_tuser !== w.sing) begin
               $display("%0t: singular expected %b actual %b", $time, w.sing, rsp_tuser);
               errors++;
            end
         end
      end
   end

   // watchdog and end of run
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cnt <= 0;
      else idle_cnt <= idle_cnt + 1;
      if (idle_cnt >= WATCH_LIMIT) begin
         $display("timeout with %0d words outstanding", inverse_queue.size());
         $display("tb: failure");
         $finish;
      end
   end

   initial begin
      wait (!reset);
      wait (!sending);
      while (inverse_queue.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      $display("sent %0d matrices, checked %0d inverses (%0d singular, %0d saturated entries)",
               n_sent, n_got, n_sing, n_sat);
      if (errors == 0 && inverse_queue.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
